### hw/rtl/itp_pkg.sv
// shared types and constants for the infix-to-postfix converter
`timescale 1ns / 1ps

package itp_pkg;

  // operator stack sizing
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int VALUE_WIDTH = 32;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] err_t;

  // token kinds
  localparam kind_t TK_OPERAND = 3'd0;
  localparam kind_t TK_ADD     = 3'd1;
  localparam kind_t TK_SUB     = 3'd2;
  localparam kind_t TK_MUL     = 3'd3;
  localparam kind_t TK_DIV     = 3'd4;
  localparam kind_t TK_LPAREN  = 3'd5;
  localparam kind_t TK_RPAREN  = 3'd6;
  localparam kind_t TK_END     = 3'd7;

  // error codes
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_UNBAL    = 2'd1;
  localparam err_t ERR_EMPTY    = 2'd2;
  localparam err_t ERR_OVERFLOW = 2'd3;

  // input word
  typedef struct packed {
    kind_t                  token_kind;
    logic [VALUE_WIDTH-1:0] operand_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                   out_valid_token;
    kind_t                  out_kind;
    logic [VALUE_WIDTH-1:0] out_value;
    err_t                   error_code;
    logic                   expr_done;
    logic                   last_of_run;
  } out_word_t;

  // stack command: push and pop together replace the top entry
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stk_cmd_t;

  // stack status seen by the sequencer
  typedef struct packed {
    logic  empty;
    logic  single;
    logic  full;
    kind_t top_kind;
    kind_t second_kind;
  } stk_stat_t;

endpackage

### hw/rtl/itp_stack.sv
// operator stack with the top two entries in registers and deeper entries in an array
`timescale 1ns / 1ps

module itp_stack (
  input  logic             clk,
  input  logic             rst_n,
  input  itp_pkg::stk_cmd_t  cmd,
  output itp_pkg::stk_stat_t stat
);

  logic [itp_pkg::CNT_W-1:0] cnt_r;
  itp_pkg::kind_t            top_r;
  itp_pkg::kind_t            second_r;
  itp_pkg::kind_t            mem_r [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::IDX_W-1:0] spill_idx;
  logic [itp_pkg::IDX_W-1:0] fill_idx;

  // slot the old second entry moves into on push, and the entry that refills it on pop
  assign spill_idx = itp_pkg::IDX_W'(cnt_r - itp_pkg::CNT_W'(2));
  assign fill_idx  = itp_pkg::IDX_W'(cnt_r - itp_pkg::CNT_W'(3));

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
    end else if (cmd.push && !cmd.pop) begin
      cnt_r <= cnt_r + itp_pkg::CNT_W'(1);
    end else if (cmd.pop && !cmd.push) begin
      cnt_r <= cnt_r - itp_pkg::CNT_W'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (!cmd.clear) begin
      if (cmd.push && cmd.pop) begin
        top_r <= cmd.kind;
      end else if (cmd.push) begin
        if (cnt_r > itp_pkg::CNT_W'(1)) begin
          mem_r[spill_idx] <= second_r;
        end
        second_r <= top_r;
        top_r    <= cmd.kind;
      end else if (cmd.pop) begin
        top_r    <= second_r;
        second_r <= mem_r[fill_idx];
      end
    end
  end

  // status
  always_comb begin
    stat.empty       = (cnt_r == '0);
    stat.single      = (cnt_r == itp_pkg::CNT_W'(1));
    stat.full        = (cnt_r == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    stat.top_kind    = top_r;
    stat.second_kind = second_r;
  end

endmodule

### hw/rtl/itp_ctrl.sv
// sequencer: decodes the held token, one stack pop per unstalled cycle, drives results
`timescale 1ns / 1ps

module itp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  itp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output itp_pkg::out_word_t out_data,
  output itp_pkg::stk_cmd_t  stk_cmd,
  input  itp_pkg::stk_stat_t stk_stat
);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t                             state_r, state_nxt;
  itp_pkg::kind_t                     tok_r, tok_nxt;
  logic [itp_pkg::VALUE_WIDTH-1:0]    val_r, val_nxt;
  logic                               emitted_r, emitted_nxt;
  logic                               err_lat_r, err_lat_nxt;
  itp_pkg::err_t                      err_kind_r, err_kind_nxt;
  logic                               out_valid_r, out_valid_nxt;
  itp_pkg::out_word_t                 out_data_r, out_data_nxt;

  // action chosen for this cycle, before the output slot gating
  logic               emit;
  itp_pkg::out_word_t res;
  itp_pkg::stk_cmd_t  cmd;
  state_t             st_act;
  logic               lat_act;
  itp_pkg::err_t      lat_code;
  logic               clr_act;
  logic               go;
  logic               out_free;
  logic               pop_op;
  logic               md_top;
  logic               second_lp;
  logic               second_md;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // shared compare on the stack top and the entry below it
  assign pop_op    = !stk_stat.empty && (stk_stat.top_kind != itp_pkg::TK_LPAREN);
  assign md_top    = !stk_stat.empty && ((stk_stat.top_kind == itp_pkg::TK_MUL) ||
                                         (stk_stat.top_kind == itp_pkg::TK_DIV));
  assign second_lp = !stk_stat.single && (stk_stat.second_kind == itp_pkg::TK_LPAREN);
  assign second_md = !stk_stat.single && ((stk_stat.second_kind == itp_pkg::TK_MUL) ||
                                          (stk_stat.second_kind == itp_pkg::TK_DIV));

  // decode of the held token into one step
  always_comb begin
    emit     = 1'b0;
    res      = '0;
    cmd      = '0;
    st_act   = state_r;
    lat_act  = 1'b0;
    lat_code = itp_pkg::ERR_NONE;
    clr_act  = 1'b0;
    if (state_r == S_BUSY) begin
      if (tok_r == itp_pkg::TK_END) begin
        if (err_lat_r) begin
          emit            = 1'b1;
          res.error_code  = err_kind_r;
          res.expr_done   = 1'b1;
          res.last_of_run = 1'b1;
          cmd.clear       = 1'b1;
          clr_act         = 1'b1;
          st_act          = S_IDLE;
        end else if (pop_op) begin
          emit                = 1'b1;
          res.out_valid_token = 1'b1;
          res.out_kind        = stk_stat.top_kind;
          cmd.pop             = 1'b1;
        end else begin
          emit            = 1'b1;
          res.expr_done   = 1'b1;
          res.last_of_run = 1'b1;
          if (!stk_stat.empty) begin
            res.error_code = itp_pkg::ERR_UNBAL;
          end else if (!emitted_r) begin
            res.error_code = itp_pkg::ERR_EMPTY;
          end else begin
            res.error_code = itp_pkg::ERR_NONE;
          end
          cmd.clear = 1'b1;
          clr_act   = 1'b1;
          st_act    = S_IDLE;
        end
      end else if (err_lat_r) begin
        // tokens after an error are dropped
        st_act = S_IDLE;
      end else begin
        case (tok_r)
          itp_pkg::TK_OPERAND: begin
            emit                = 1'b1;
            res.out_valid_token = 1'b1;
            res.out_kind        = itp_pkg::TK_OPERAND;
            res.out_value       = val_r;
            res.last_of_run     = 1'b1;
            st_act              = S_IDLE;
          end
          itp_pkg::TK_MUL, itp_pkg::TK_DIV,
          itp_pkg::TK_ADD, itp_pkg::TK_SUB,
          itp_pkg::TK_LPAREN: begin
            if ((tok_r == itp_pkg::TK_MUL || tok_r == itp_pkg::TK_DIV) ? md_top :
                (tok_r != itp_pkg::TK_LPAREN) && pop_op) begin
              // pop one operator; the final pop also pushes the new one
              emit                = 1'b1;
              res.out_valid_token = 1'b1;
              res.out_kind        = stk_stat.top_kind;
              cmd.pop             = 1'b1;
              res.last_of_run     = (tok_r == itp_pkg::TK_MUL || tok_r == itp_pkg::TK_DIV) ?
                                    !second_md : (stk_stat.single || second_lp);
              if (res.last_of_run) begin
                cmd.push = 1'b1;
                cmd.kind = tok_r;
                st_act   = S_IDLE;
              end
            end else if (stk_stat.full) begin
              emit            = 1'b1;
              res.error_code  = itp_pkg::ERR_OVERFLOW;
              res.last_of_run = 1'b1;
              lat_act         = 1'b1;
              lat_code        = itp_pkg::ERR_OVERFLOW;
              st_act          = S_IDLE;
            end else begin
              cmd.push = 1'b1;
              cmd.kind = tok_r;
              st_act   = S_IDLE;
            end
          end
          itp_pkg::TK_RPAREN: begin
            if (pop_op) begin
              emit                = 1'b1;
              res.out_valid_token = 1'b1;
              res.out_kind        = stk_stat.top_kind;
              res.last_of_run     = second_lp;
              cmd.pop             = 1'b1;
            end else if (stk_stat.empty) begin
              emit            = 1'b1;
              res.error_code  = itp_pkg::ERR_UNBAL;
              res.last_of_run = 1'b1;
              lat_act         = 1'b1;
              lat_code        = itp_pkg::ERR_UNBAL;
              st_act          = S_IDLE;
            end else begin
              // matching left paren, dropped silently
              cmd.pop = 1'b1;
              st_act  = S_IDLE;
            end
          end
          default: begin
            st_act = S_IDLE;
          end
        endcase
      end
    end
  end

  // a step that produces a result waits for a free output slot
  assign go      = !emit || out_free;
  assign stk_cmd = go ? cmd : '0;

  // next-state values
  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    val_nxt       = val_r;
    emitted_nxt   = emitted_r;
    err_lat_nxt   = err_lat_r;
    err_kind_nxt  = err_kind_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == S_IDLE) begin
      if (in_valid) begin
        tok_nxt   = in_data.token_kind;
        val_nxt   = in_data.operand_value;
        state_nxt = S_BUSY;
      end
    end else if (go) begin
      state_nxt = st_act;
      if (emit) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
        if (res.out_valid_token) begin
          emitted_nxt = 1'b1;
        end
      end
      if (lat_act) begin
        err_lat_nxt  = 1'b1;
        err_kind_nxt = lat_code;
      end
      if (clr_act) begin
        emitted_nxt  = 1'b0;
        err_lat_nxt  = 1'b0;
        err_kind_nxt = itp_pkg::ERR_NONE;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emitted_r   <= 1'b0;
      err_lat_r   <= 1'b0;
      err_kind_r  <= itp_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emitted_r   <= emitted_nxt;
      err_lat_r   <= err_lat_nxt;
      err_kind_r  <= err_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tok_r      <= tok_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/infix_to_postfix_converter_top.sv
// top level of the infix-to-postfix converter
`timescale 1ns / 1ps
// Usage: feed one infix token per input word on in_valid/in_stall/in_data
// (operand with value, + - * /, parentheses, end of expression). Postfix
// tokens and status words leave on out_valid/out_stall/out_data; the last
// word caused by an input carries last_of_run, and the end token always
// yields one status word with expr_done and the error code.
// Timing: an input is taken while idle and then worked through in stack
// steps. An operand or a silent push is done in its first step; an
// operator takes a pop step per stacked operator that it pops, the last
// pop also pushing it (a right paren adds a step dropping its left paren,
// an end token a step for the done word). The stack is stepped once per
// cycle by one compare unit, but when out_stall is high the sequencer
// holds its step until the output register frees; in_stall stays high
// until the token is finished. The output register lets a new input be
// taken while the last word of the previous one still waits.
// Reset (rst_n low, synchronous) empties the stack, clears the error latch
// and drops any pending output word; no clearing pass is needed.

module infix_to_postfix_converter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  itp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output itp_pkg::out_word_t out_data
);

  itp_pkg::stk_cmd_t  stk_cmd;
  itp_pkg::stk_stat_t stk_stat;

  // token sequencer and output register
  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stk_cmd   (stk_cmd),
    .stk_stat  (stk_stat)
  );

  // operator stack
  itp_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

endmodule

### tb/postfix_checker.sv
// checker for the infix-to-postfix converter: predicts and compares result words
`timescale 1ns / 1ps

module postfix_checker
  import itp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        mismatches,
  output int        words_pending
);

  // predicted converter state
  kind_t     op_stack [STACK_DEPTH];
  int        stack_fill;
  logic      token_emitted;
  logic      err_held;
  err_t      err_code_held;

  // words caused by the current token, and words still owed by the block
  out_word_t token_words [$];
  out_word_t expected_words [$];
  int        fail_tally;

  initial begin
    stack_fill    = 0;
    token_emitted = 1'b0;
    err_held      = 1'b0;
    err_code_held = ERR_NONE;
    fail_tally    = 0;
  end

  task automatic clear_converter();
    stack_fill    = 0;
    token_emitted = 1'b0;
    err_held      = 1'b0;
    err_code_held = ERR_NONE;
  endtask

  task automatic put_word(input logic tok, input kind_t kind,
                          input logic [VALUE_WIDTH-1:0] value, input err_t err,
                          input logic done);
    out_word_t w;
    w.out_valid_token = tok;
    w.out_kind        = kind;
    w.out_value       = value;
    w.error_code      = err;
    w.expr_done       = done;
    w.last_of_run     = 1'b0;
    token_words.insert(token_words.size(), w);
    if (tok) begin
      token_emitted = 1'b1;
    end
  endtask

  function automatic kind_t top_of_stack();
    if (stack_fill == 0) begin
      return TK_OPERAND;
    end
    return op_stack[stack_fill-1];
  endfunction

  // move the top operator to the postfix stream
  task automatic pop_to_output();
    put_word(1'b1, op_stack[stack_fill-1], '0, ERR_NONE, 1'b0);
    stack_fill--;
  endtask

  task automatic raise_error(input err_t err);
    err_held      = 1'b1;
    err_code_held = err;
    put_word(1'b0, TK_OPERAND, '0, err, 1'b0);
  endtask

  task automatic push_op(input kind_t kind);
    if (stack_fill >= STACK_DEPTH) begin
      raise_error(ERR_OVERFLOW);
    end else begin
      op_stack[stack_fill] = kind;
      stack_fill++;
    end
  endtask

  // flush at end of expression and report the outcome
  task automatic close_expression();
    err_t err;
    err = ERR_NONE;
    if (err_held) begin
      err = err_code_held;
    end else begin
      while (stack_fill > 0 && top_of_stack() != TK_LPAREN) pop_to_output();
      if (stack_fill > 0) begin
        err = ERR_UNBAL;
      end else if (!token_emitted) begin
        err = ERR_EMPTY;
      end
    end
    put_word(1'b0, TK_OPERAND, '0, err, 1'b1);
    clear_converter();
  endtask

  // shunting-yard step for one accepted token
  task automatic convert_token(input in_word_t w);
    out_word_t last_w;
    token_words.delete();
    if (w.token_kind == TK_END) begin
      close_expression();
    end else if (!err_held) begin
      case (w.token_kind)
        TK_OPERAND: begin
          put_word(1'b1, TK_OPERAND, w.operand_value, ERR_NONE, 1'b0);
        end
        TK_MUL, TK_DIV: begin
          while (top_of_stack() == TK_MUL || top_of_stack() == TK_DIV) pop_to_output();
          push_op(w.token_kind);
        end
        TK_ADD, TK_SUB: begin
          while (stack_fill > 0 && top_of_stack() != TK_LPAREN) pop_to_output();
          push_op(w.token_kind);
        end
        TK_LPAREN: begin
          push_op(TK_LPAREN);
        end
        default: begin
          // right paren: pop down to the match, or flag a stray one
          while (stack_fill > 0 && top_of_stack() != TK_LPAREN) pop_to_output();
          if (stack_fill == 0) begin
            raise_error(ERR_UNBAL);
          end else begin
            stack_fill--;
          end
        end
      endcase
    end
    if (token_words.size() > 0) begin
      last_w = token_words[token_words.size()-1];
      last_w.last_of_run = 1'b1;
      token_words[token_words.size()-1] = last_w;
    end
    foreach (token_words[i]) expected_words.insert(expected_words.size(), token_words[i]);
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      clear_converter();
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        convert_token(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_words.pop_front();
          if (out_data !== want) begin
            fail_tally++;
            $display("%0t: mismatch, expected tok=%b kind=%0d value=%h err=%0d done=%b last=%b",
                     $time, want.out_valid_token, want.out_kind, want.out_value,
                     want.error_code, want.expr_done, want.last_of_run);
            $display("%0t:           actual   tok=%b kind=%0d value=%h err=%0d done=%b last=%b",
                     $time, out_data.out_valid_token, out_data.out_kind, out_data.out_value,
                     out_data.error_code, out_data.expr_done, out_data.last_of_run);
          end
        end
      end
    end
    mismatches    <= fail_tally;
    words_pending <= expected_words.size();
  end

endmodule

### tb/testbench.sv
// testbench top for the infix-to-postfix converter: stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import itp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 149;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;

  int        mismatches;
  int        words_pending;
  int        send_idle_pct  = 10;
  int        recv_stall_pct = 57;
  int        items_sent     = 0;
  int        cycle_count    = 0;
  in_word_t  tokens [$];

  always #2 clk = ~clk;

  infix_to_postfix_converter_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  postfix_checker CHECK (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_token(input kind_t kind, input logic [VALUE_WIDTH-1:0] value);
    in_word_t w;
    w.token_kind    = kind;
    w.operand_value = value;
    tokens.insert(tokens.size(), w);
  endtask

  // operand words lean toward the extremes now and then
  function automatic logic [VALUE_WIDTH-1:0] operand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic gen_term(input int depth);
    if (depth > 0 && $urandom_range(0, 2) == 0) begin
      add_token(TK_LPAREN, $urandom);
      gen_sum(depth - 1);
      add_token(TK_RPAREN, $urandom);
    end else begin
      add_token(TK_OPERAND, operand_word());
    end
  endtask

  task automatic gen_sum(input int depth);
    int n;
    n = $urandom_range(0, 3);
    gen_term(depth);
    repeat (n) begin
      add_token(kind_t'($urandom_range(TK_ADD, TK_DIV)), $urandom);
      gen_term(depth);
    end
  endtask

  // one expression: mostly well formed, some deep nesting, broken or noise
  task automatic gen_expression();
    int       sel;
    int       j;
    int       nest;
    in_word_t w;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      gen_sum($urandom_range(0, 5));
    end else if (sel < 78) begin
      // deep nesting, past the stack size about half the time
      nest = $urandom_range(12, 20);
      repeat (nest) add_token(TK_LPAREN, $urandom);
      gen_sum(1);
      repeat ($urandom_range(0, nest)) add_token(TK_RPAREN, $urandom);
    end else if (sel < 90) begin
      // well formed body with one token corrupted or dropped
      gen_sum($urandom_range(1, 4));
      j = $urandom_range(0, tokens.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        tokens.delete(j);
      end else begin
        w = tokens[j];
        w.token_kind = kind_t'($urandom_range(TK_OPERAND, TK_RPAREN));
        tokens[j] = w;
      end
    end else begin
      repeat ($urandom_range(0, 8)) begin
        add_token(kind_t'($urandom_range(TK_OPERAND, TK_RPAREN)), $urandom);
      end
    end
    add_token(TK_END, $urandom);
  endtask

  // send queued tokens, one word per handshake, with random gaps
  task automatic send_tokens();
    in_word_t w;
    while (tokens.size() > 0) begin
      w = tokens.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      items_sent++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty expression
    add_token(TK_END, 32'h0);
    // 0 + ffffffff * 5 / 7 - 3
    add_token(TK_OPERAND, '0);
    add_token(TK_ADD, '1);
    add_token(TK_OPERAND, '1);
    add_token(TK_MUL, 32'h0);
    add_token(TK_OPERAND, 32'd5);
    add_token(TK_DIV, '1);
    add_token(TK_OPERAND, 32'd7);
    add_token(TK_SUB, 32'h0);
    add_token(TK_OPERAND, 32'd3);
    add_token(TK_END, '1);
    // ( 1 ) + 2 ) 4 : stray right paren, then an ignored operand
    add_token(TK_LPAREN, 32'h0);
    add_token(TK_OPERAND, 32'd1);
    add_token(TK_RPAREN, '1);
    add_token(TK_ADD, 32'h0);
    add_token(TK_OPERAND, 32'd2);
    add_token(TK_RPAREN, 32'h0);
    add_token(TK_OPERAND, 32'd4);
    add_token(TK_END, 32'h0);
    // ( 1 + : left paren still open at end
    add_token(TK_LPAREN, '1);
    add_token(TK_OPERAND, 32'h8000_0001);
    add_token(TK_ADD, 32'h0);
    add_token(TK_END, '1);
    send_tokens();

    // random phases with shifting idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 57;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (items_sent < 23 + PHASE_ITEMS * (phase + 1)) begin
        gen_expression();
        send_tokens();
      end
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
